### rtl/core/eolr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eolr_pkg: shared types and helpers for the eight-octant line rasterizer
// Beat formats, octant codes and the octant mirror functions.
// ----------------------------------------------------------------------------
package eolr_pkg;

    localparam int COORD_BITS = 12;
    localparam int PW = COORD_BITS + 1;   // mirrored coordinates and deltas
    localparam int IW = COORD_BITS + 3;   // decision increments
    localparam int DW = COORD_BITS + 4;   // decision variable

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef enum logic [2:0] {
        OCT_0, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7
    } t_octant;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_in_beat;

    typedef struct packed {
        logic                         pixel_valid;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         last_pixel;
    } t_out_beat;

    typedef struct packed {
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] b;
    } t_point;

    // true (x, y) -> octant-0 (major, minor)
    function automatic t_point to_oct0(input t_octant oct,
                                       input logic signed [PW-1:0] x,
                                       input logic signed [PW-1:0] y);
        t_point p;
        unique case (oct)
            OCT_0:   begin p.a = x;  p.b = y;  end
            OCT_1:   begin p.a = y;  p.b = x;  end
            OCT_2:   begin p.a = y;  p.b = -x; end
            OCT_3:   begin p.a = -x; p.b = y;  end
            OCT_4:   begin p.a = -x; p.b = -y; end
            OCT_5:   begin p.a = -y; p.b = -x; end
            OCT_6:   begin p.a = -y; p.b = x;  end
            default: begin p.a = x;  p.b = -y; end
        endcase
        return p;
    endfunction

    // octant-0 (major, minor) -> true (x, y), returned as (a = x, b = y)
    function automatic t_point from_oct0(input t_octant oct,
                                         input logic signed [PW-1:0] a,
                                         input logic signed [PW-1:0] b);
        t_point p;
        unique case (oct)
            OCT_0:   begin p.a = a;  p.b = b;  end
            OCT_1:   begin p.a = b;  p.b = a;  end
            OCT_2:   begin p.a = -b; p.b = a;  end
            OCT_3:   begin p.a = -a; p.b = b;  end
            OCT_4:   begin p.a = -a; p.b = -b; end
            OCT_5:   begin p.a = -b; p.b = -a; end
            OCT_6:   begin p.a = b;  p.b = -a; end
            default: begin p.a = a;  p.b = -b; end
        endcase
        return p;
    endfunction

endpackage

### rtl/core/eight_octant_line_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_octant_line_rasterizer_top: midpoint line generator, all octants
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries load and step
//   beats. A load beat (mode 0) latches the endpoints, picks the octant and
//   sets up the decision variable; it yields no output beat. A load while a
//   line is in progress replaces that line. A step beat (mode 1) yields one
//   output beat on (o_out_valid / i_out_stall / o_out_data) holding the next
//   pixel in true coordinates, last_pixel set on the final one. A step with
//   no line in progress yields a beat with all fields zero.
//   A beat is held in the input register; a step beat's result is then
//   written to the output register, where the receiver can take it.
//   Throughput: one beat per cycle while no step beat waits on a full
//   output, set by the single add-and-compare update of the decision
//   variable between the two registers.
//   When the receiver stalls, the output beat holds and the input register
//   keeps taking beats until a step beat finds the output still full; then
//   o_in_stall rises. Load beats pass through without waiting on the output.
//   Reset clears the line state, so the block comes up idle and empty.
// ----------------------------------------------------------------------------
module eight_octant_line_rasterizer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  eolr_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output eolr_pkg::t_out_beat o_out_data
);

    localparam int CW = eolr_pkg::COORD_BITS;
    localparam int PW = eolr_pkg::PW;
    localparam int IW = eolr_pkg::IW;
    localparam int DW = eolr_pkg::DW;

    logic                r_in_valid;
    eolr_pkg::t_in_beat  r_in_data;
    logic                r_out_valid;
    eolr_pkg::t_out_beat r_out_data;

    logic                 r_line_active;
    eolr_pkg::t_octant    r_octant;
    logic signed [PW-1:0] r_major_pos;
    logic signed [PW-1:0] r_minor_pos;
    logic signed [PW-1:0] r_major_end;
    logic signed [DW-1:0] r_decision;
    logic signed [IW-1:0] r_east_inc;
    logic signed [IW-1:0] r_diag_inc;

    logic is_load, is_step, out_free, advance, in_accept;

    // load setup
    logic signed [PW-1:0] x0, y0, x1, y1, dx, dy, adx, ady, da, db;
    logic                 shallow;
    eolr_pkg::t_octant    n_octant;
    eolr_pkg::t_point     p_start, p_end;

    // step
    logic                 last;
    eolr_pkg::t_point     p_true;
    eolr_pkg::t_out_beat  n_out_data;

    assign is_load   = (r_in_data.mode == eolr_pkg::MODE_LOAD);
    assign is_step   = (r_in_data.mode == eolr_pkg::MODE_STEP);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = r_in_valid && (is_load || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        x0 = PW'(r_in_data.start_x);
        y0 = PW'(r_in_data.start_y);
        x1 = PW'(r_in_data.end_x);
        y1 = PW'(r_in_data.end_y);
        dx = x1 - x0;
        dy = y1 - y0;
        adx = dx[PW-1] ? -dx : dx;
        ady = dy[PW-1] ? -dy : dy;
        shallow = (adx >= ady);
        if (shallow) begin
            da = adx;
            db = ady;
        end else begin
            da = ady;
            db = adx;
        end
        case ({shallow, dx[PW-1], dy[PW-1]})
            3'b100:  n_octant = eolr_pkg::OCT_0;
            3'b101:  n_octant = eolr_pkg::OCT_7;
            3'b110:  n_octant = eolr_pkg::OCT_3;
            3'b111:  n_octant = eolr_pkg::OCT_4;
            3'b000:  n_octant = eolr_pkg::OCT_1;
            3'b001:  n_octant = eolr_pkg::OCT_6;
            3'b010:  n_octant = eolr_pkg::OCT_2;
            default: n_octant = eolr_pkg::OCT_5;
        endcase
        p_start = eolr_pkg::to_oct0(n_octant, x0, y0);
        p_end   = eolr_pkg::to_oct0(n_octant, x1, y1);
    end

    always_comb begin
        last   = (r_major_pos >= r_major_end);
        p_true = eolr_pkg::from_oct0(r_octant, r_major_pos, r_minor_pos);
        n_out_data = '0;
        if (r_line_active) begin
            n_out_data.pixel_valid = 1'b1;
            n_out_data.pixel_x     = p_true.a[CW-1:0];
            n_out_data.pixel_y     = p_true.b[CW-1:0];
            n_out_data.last_pixel  = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_step) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_octant      <= eolr_pkg::OCT_0;
            r_major_pos   <= '0;
            r_minor_pos   <= '0;
            r_major_end   <= '0;
            r_decision    <= '0;
            r_east_inc    <= '0;
            r_diag_inc    <= '0;
        end else if (advance && is_load) begin
            r_line_active <= 1'b1;
            r_octant      <= n_octant;
            r_major_pos   <= p_start.a;
            r_minor_pos   <= p_start.b;
            r_major_end   <= p_end.a;
            r_decision    <= (DW'(db) <<< 1) - DW'(da);
            r_east_inc    <= IW'(db) <<< 1;
            r_diag_inc    <= (IW'(db) - IW'(da)) <<< 1;
        end else if (advance && is_step && r_line_active) begin
            if (last) begin
                r_line_active <= 1'b0;
            end else begin
                if (r_decision[DW-1]) begin
                    r_decision <= r_decision + DW'(r_east_inc);
                end else begin
                    r_decision  <= r_decision + DW'(r_diag_inc);
                    r_minor_pos <= r_minor_pos + PW'(1);
                end
                r_major_pos <= r_major_pos + PW'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_load_starts_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_load) |=> r_line_active)
        else $error("load beat did not start a line");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_step && r_line_active && last) |=> !r_line_active)
        else $error("line still active after last pixel");

    a_major_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_major_pos <= r_major_end))
        else $error("major position ran past line end");

    a_last_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.last_pixel) |-> r_out_data.pixel_valid)
        else $error("last flag on a beat without a pixel");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && is_step && r_out_valid))
        else $error("input stalled with no blocked step beat");

endmodule
